[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication check
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication check
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/sgbf_pkg.sv]
// ----------------------------------------------------------------------------
// sgbf_pkg
// Shared constants, command and state types of the band filter.
// ----------------------------------------------------------------------------
package sgbf_pkg;

  localparam int unsigned CHANNELS    = 16;
  localparam int unsigned CH_W        = 4;
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned KNOB_W      = 17;
  localparam int unsigned CV_W        = 17;
  localparam int unsigned TGT_W       = 17;
  localparam int unsigned LAST_W      = 27;
  localparam int unsigned ACC_W       = 62;
  localparam int unsigned MUL_A_W     = 34;
  localparam int unsigned MUL_B_W     = 28;
  localparam int unsigned REM_W       = 46;
  localparam int unsigned MEM_DEPTH   = 96;
  localparam int unsigned MEM_AW      = 7;
  localparam int unsigned PADDR_W     = 3;

  localparam logic [KNOB_W-1:0] LP_KNOB_RST = 17'd65536;
  localparam logic [KNOB_W-1:0] HP_KNOB_RST = 17'd0;
  localparam logic [KNOB_W-1:0] COEF_ONE    = 17'd65536;
  localparam logic [LAST_W-1:0] LAST_RST    = 27'(1000 * 65536);
  localparam logic [LAST_W-1:0] DEN_OFS     = 27'(301 * 65536);

  localparam logic signed [22:0] CLAMP_LO5 = 23'sd3275;
  localparam logic signed [22:0] CLAMP_HI5 = 23'sd324405;
  localparam logic [MUL_B_W-1:0] RECIP5    = 28'd838861;
  localparam logic [4:0]         DIV_TOP   = 5'd16;

  localparam logic REG_LP = 1'b0;
  localparam logic REG_HP = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_RECIP, OP_SQUARE, OP_TGT, OP_MAG, OP_DIV_INIT, OP_DIV,
    OP_AMT, OP_GEAR, OP_RD, OP_HP_M1, OP_HP_M2, OP_HP_FIN, OP_LP_M1, OP_LP_M2,
    OP_LP_FIN, OP_OUT
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RECIP, ST_SQUARE, ST_TGT, ST_MAG, ST_DIV_INIT, ST_DIV, ST_AMT,
    ST_GEAR, ST_RD, ST_HP_M1, ST_HP_M2, ST_HP_FIN, ST_LP_M1, ST_LP_M2,
    ST_LP_FIN, ST_OUT
  } state_e;

  typedef struct packed {
    op_e        op;
    logic       side;
    logic [1:0] stage;
    logic [4:0] bit_idx;
  } cmd_t;

endpackage

[sv/sgbf_ctrl.sv]
// ----------------------------------------------------------------------------
// sgbf_ctrl
// Sequencer: steps the shared datapath through one sample.
// ----------------------------------------------------------------------------
module sgbf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_free_i,
  output logic          in_ready_o,
  output sgbf_pkg::cmd_t cmd_o
);
  import sgbf_pkg::*;

  state_e     state_q, state_d;
  logic       side_q, side_d;
  logic [1:0] stage_q, stage_d;
  logic [4:0] bit_q, bit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      side_q  <= 1'b0;
      stage_q <= 2'd0;
      bit_q   <= 5'd0;
    end else begin
      state_q <= state_d;
      side_q  <= side_d;
      stage_q <= stage_d;
      bit_q   <= bit_d;
    end
  end

  always_comb begin
    state_d = state_q;
    side_d  = side_q;
    stage_d = stage_q;
    bit_d   = bit_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RECIP;
          side_d  = 1'b0;
        end
      end
      ST_RECIP:    state_d = ST_SQUARE;
      ST_SQUARE:   state_d = ST_TGT;
      ST_TGT:      state_d = ST_MAG;
      ST_MAG:      state_d = ST_DIV_INIT;
      ST_DIV_INIT: begin
        state_d = ST_DIV;
        bit_d   = DIV_TOP;
      end
      ST_DIV: begin
        if (bit_q == 5'd0) state_d = ST_AMT;
        else bit_d = bit_q - 5'd1;
      end
      ST_AMT: begin
        if (side_q) begin
          state_d = ST_GEAR;
        end else begin
          side_d  = 1'b1;
          state_d = ST_RECIP;
        end
      end
      ST_GEAR: begin
        state_d = ST_RD;
        stage_d = 2'd0;
      end
      ST_RD:     state_d = ST_HP_M1;
      ST_HP_M1:  state_d = ST_HP_M2;
      ST_HP_M2:  state_d = ST_HP_FIN;
      ST_HP_FIN: state_d = ST_LP_M1;
      ST_LP_M1:  state_d = ST_LP_M2;
      ST_LP_M2:  state_d = ST_LP_FIN;
      ST_LP_FIN: begin
        if (stage_q == 2'd2) begin
          state_d = ST_OUT;
        end else begin
          stage_d = stage_q + 2'd1;
          state_d = ST_RD;
        end
      end
      ST_OUT: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.side    = side_q;
    cmd_o.stage   = stage_q;
    cmd_o.bit_idx = bit_q;
    in_ready_o    = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE:     cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      ST_RECIP:    cmd_o.op = OP_RECIP;
      ST_SQUARE:   cmd_o.op = OP_SQUARE;
      ST_TGT:      cmd_o.op = OP_TGT;
      ST_MAG:      cmd_o.op = OP_MAG;
      ST_DIV_INIT: cmd_o.op = OP_DIV_INIT;
      ST_DIV:      cmd_o.op = OP_DIV;
      ST_AMT:      cmd_o.op = OP_AMT;
      ST_GEAR:     cmd_o.op = OP_GEAR;
      ST_RD:       cmd_o.op = OP_RD;
      ST_HP_M1:    cmd_o.op = OP_HP_M1;
      ST_HP_M2:    cmd_o.op = OP_HP_M2;
      ST_HP_FIN:   cmd_o.op = OP_HP_FIN;
      ST_LP_M1:    cmd_o.op = OP_LP_M1;
      ST_LP_M2:    cmd_o.op = OP_LP_M2;
      ST_LP_FIN:   cmd_o.op = OP_LP_FIN;
      ST_OUT:      cmd_o.op = out_free_i ? OP_OUT : OP_NONE;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

endmodule

[sv/sgbf_dp.sv]
// ----------------------------------------------------------------------------
// sgbf_dp
// Datapath: channel state, pole memory, shared multiplier and divider.
// ----------------------------------------------------------------------------
module sgbf_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sgbf_pkg::cmd_t                        cmd_i,
  input  logic [sgbf_pkg::KNOB_W-1:0]           lp_knob_i,
  input  logic [sgbf_pkg::KNOB_W-1:0]           hp_knob_i,
  input  logic [sgbf_pkg::CH_W-1:0]             channel_i,
  input  logic signed [sgbf_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic signed [sgbf_pkg::CV_W-1:0]      lowpass_cv_i,
  input  logic signed [sgbf_pkg::CV_W-1:0]      highpass_cv_i,
  input  logic                                 out_ready_i,
  output logic                                 out_free_o,
  output logic                                 out_valid_o,
  output logic [sgbf_pkg::CH_W-1:0]             channel_out_o,
  output logic signed [sgbf_pkg::SAMPLE_BITS-1:0] sample_out_o
);
  import sgbf_pkg::*;

  // per-channel state
  logic [KNOB_W-1:0] lp_amt_q [CHANNELS];
  logic [KNOB_W-1:0] hp_amt_q [CHANNELS];
  logic [LAST_W-1:0] lp_last_q [CHANNELS];
  logic [LAST_W-1:0] hp_last_q [CHANNELS];
  logic [2:0]        gear_q [CHANNELS];

  // pole memory: {highpass, lowpass}
  logic [63:0]          mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] pv_q;
  logic [63:0]          rd_raw_q;
  logic                 rd_v_q;
  logic [MEM_AW-1:0]    addr_q, addr_d;

  logic [CH_W-1:0]          ch_q;
  logic signed [31:0]       x_q;
  logic signed [CV_W-1:0]   cv_lp_q, cv_hp_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [TGT_W-1:0]         tgt_q;
  logic [LAST_W-1:0]        den_q;
  logic                     neg_q;
  logic [REM_W-1:0]         rem_q;
  logic [TGT_W-1:0]         quo_q;
  logic [KNOB_W-1:0]        lpa_q, hpa_q;
  logic [2:0]               g_q;
  logic signed [31:0]       hp_new_q;
  logic signed [32:0]       xw_q;
  logic                     out_valid_q;
  logic [CH_W-1:0]          out_ch_q;
  logic signed [SAMPLE_BITS-1:0] out_y_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [ACC_W-1:0]   mul_p;

  logic [KNOB_W-1:0]      knob_s, amt_old, amt_new;
  logic signed [CV_W-1:0] cv_s;
  logic signed [22:0]     t5, t5c;
  logic [15:0]            p;
  logic [LAST_W-1:0]      last_old, d_abs;
  logic signed [LAST_W:0] d_s;
  logic signed [17:0]     diff_s;
  logic [16:0]            diff_abs;
  logic [REM_W-1:0]       trial;
  logic signed [17:0]     one_m_hp, one_m_lp;
  logic signed [ACC_W-1:0] rnd_sh;
  logic signed [31:0]     pole_new;
  logic signed [32:0]     y33, y_sh;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic [2:0]             g_next;
  logic [2:0]             kk;
  logic [63:0]            rd;

  assign mul_p = mul_a * mul_b;

  assign knob_s   = cmd_i.side ? hp_knob_i : lp_knob_i;
  assign cv_s     = cmd_i.side ? cv_hp_q : cv_lp_q;
  assign amt_old  = cmd_i.side ? hp_amt_q[ch_q] : lp_amt_q[ch_q];
  assign last_old = cmd_i.side ? hp_last_q[ch_q] : lp_last_q[ch_q];

  assign t5 = $signed({6'b0, knob_s}) + $signed({4'b0, knob_s, 2'b0})
            + $signed({{2{cv_s[CV_W-1]}}, cv_s, 4'b0});
  assign t5c = (t5 < CLAMP_LO5) ? CLAMP_LO5 : ((t5 > CLAMP_HI5) ? CLAMP_HI5 : t5);
  assign p   = acc_q[37:22];

  assign d_s      = $signed({1'b0, last_old}) - $signed({11'b0, tgt_q});
  assign d_abs    = d_s[LAST_W] ? LAST_W'(-d_s) : d_s[LAST_W-1:0];
  assign diff_s   = $signed({1'b0, tgt_q}) - $signed({1'b0, amt_old});
  assign diff_abs = diff_s[17] ? 17'(-diff_s) : diff_s[16:0];
  assign trial    = REM_W'(den_q) << cmd_i.bit_idx;
  assign amt_new  = neg_q ? amt_old - quo_q : amt_old + quo_q;

  assign one_m_hp = $signed({1'b0, COEF_ONE}) - $signed({1'b0, hpa_q});
  assign one_m_lp = $signed({1'b0, COEF_ONE}) - $signed({1'b0, lpa_q});
  assign rd       = rd_v_q ? rd_raw_q : 64'd0;

  // round half up, floor shift, saturate to 32 bits
  assign rnd_sh = (acc_q + 62'sd32768) >>> 16;
  assign pole_new = (rnd_sh > 62'sd2147483647) ? 32'sh7fffffff :
                    (rnd_sh < -62'sd2147483648) ? 32'sh80000000 : rnd_sh[31:0];

  assign y33   = $signed({x_q[31], x_q}) + 33'sd128;
  assign y_sh  = y33 >>> 8;
  assign y_sat = (y_sh > 33'sd8388607) ? 24'sh7fffff :
                 (y_sh < -33'sd8388608) ? 24'sh800000 : y_sh[23:0];

  assign g_next = (gear_q[ch_q] == 3'd5) ? 3'd0 : gear_q[ch_q] + 3'd1;

  always_comb begin
    case (cmd_i.stage)
      2'd0: kk = 3'd0;
      2'd1: kk = g_q[0] ? 3'd2 : 3'd1;
      default: begin
        case (g_q)
          3'd0, 3'd3: kk = 3'd3;
          3'd1, 3'd4: kk = 3'd4;
          default:    kk = 3'd5;
        endcase
      end
    endcase
    addr_d = MEM_AW'({ch_q, 2'b0}) + MEM_AW'({ch_q, 1'b0}) + MEM_AW'(kk);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_RECIP: begin
        mul_a = MUL_A_W'(t5c);
        mul_b = $signed(RECIP5);
      end
      OP_SQUARE: begin
        mul_a = $signed({18'b0, p});
        mul_b = $signed({12'b0, p});
      end
      OP_MAG: begin
        mul_a = $signed({17'b0, diff_abs});
        mul_b = $signed({1'b0, d_abs + LAST_W'(COEF_ONE)});
      end
      OP_HP_M1: begin
        mul_a = MUL_A_W'($signed(rd[63:32]));
        mul_b = MUL_B_W'(one_m_hp);
      end
      OP_HP_M2: begin
        mul_a = MUL_A_W'(x_q);
        mul_b = $signed({11'b0, hpa_q});
      end
      OP_LP_M1: begin
        mul_a = MUL_A_W'($signed(rd[31:0]));
        mul_b = MUL_B_W'(one_m_lp);
      end
      OP_LP_M2: begin
        mul_a = MUL_A_W'(xw_q);
        mul_b = $signed({11'b0, lpa_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        lp_amt_q[c]  <= COEF_ONE;
        hp_amt_q[c]  <= '0;
        lp_last_q[c] <= LAST_RST;
        hp_last_q[c] <= LAST_RST;
        gear_q[c]    <= 3'd0;
      end
      pv_q        <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_OUT) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_MAG: begin
          if (cmd_i.side == REG_HP) hp_last_q[ch_q] <= LAST_W'(tgt_q);
          else lp_last_q[ch_q] <= LAST_W'(tgt_q);
        end
        OP_AMT: begin
          if (cmd_i.side == REG_HP) hp_amt_q[ch_q] <= amt_new;
          else lp_amt_q[ch_q] <= amt_new;
        end
        OP_GEAR:   gear_q[ch_q] <= g_next;
        OP_RD:     rd_v_q <= pv_q[addr_d];
        OP_LP_FIN: pv_q[addr_q] <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        ch_q    <= channel_i;
        x_q     <= $signed({sample_in_i, 8'b0});
        cv_lp_q <= lowpass_cv_i;
        cv_hp_q <= highpass_cv_i;
      end
      OP_RECIP, OP_SQUARE, OP_MAG, OP_HP_M1, OP_LP_M1: acc_q <= mul_p;
      OP_HP_M2, OP_LP_M2: acc_q <= acc_q + mul_p;
      OP_TGT: tgt_q <= TGT_W'((acc_q[32:0] + 33'd32768) >> 16);
      OP_DIV_INIT: begin
        rem_q <= REM_W'(acc_q[44:0]) + REM_W'(den_q >> 1);
        quo_q <= '0;
      end
      OP_DIV: begin
        if (rem_q >= trial) begin
          rem_q <= rem_q - trial;
          quo_q[cmd_i.bit_idx] <= 1'b1;
        end
      end
      OP_AMT: begin
        if (cmd_i.side == REG_HP) hpa_q <= amt_new;
        else lpa_q <= amt_new;
      end
      OP_GEAR: g_q <= g_next;
      OP_HP_FIN: begin
        hp_new_q <= pole_new;
        xw_q     <= $signed({x_q[31], x_q}) - $signed({pole_new[31], pole_new});
      end
      OP_LP_FIN: x_q <= pole_new;
      OP_OUT: begin
        out_ch_q <= ch_q;
        out_y_q  <= y_sat;
      end
      default: ;
    endcase
    if (cmd_i.op == OP_MAG) begin
      den_q <= d_abs + DEN_OFS;
      neg_q <= diff_s[17];
    end
    if (cmd_i.op == OP_RD) addr_q <= addr_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LP_FIN) mem[addr_q] <= {hp_new_q, pole_new};
    if (cmd_i.op == OP_RD) rd_raw_q <= mem[addr_d];
  end

  assign out_free_o    = !out_valid_q || out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign channel_out_o = out_ch_q;
  assign sample_out_o  = out_y_q;

endmodule

[sv/smoothed_gearbox_iir_bandfilter_core.sv]
// ----------------------------------------------------------------------------
// smoothed_gearbox_iir_bandfilter_core
// Sixteen-channel three-pole-pair highpass/lowpass filter with smoothed
// control-voltage coefficients and a rotating pole gear.
// ----------------------------------------------------------------------------
// One sample at a time: an accepted item is worked through in full before the
// next one is taken. Its duration is set by the single shared multiplier and the
// bit-serial divider of coefficient smoothing (two 17-step divisions, one per
// filter side) plus twelve multiplies for the six pole updates. The result
// waits in an output register, so the next item is accepted while it is held.
// Knob registers: lowpass at 0x0, highpass at 0x4.
module smoothed_gearbox_iir_bandfilter_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sgbf_pkg::PADDR_W-1:0]           paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [sgbf_pkg::CH_W-1:0]              channel_i,
  input  logic signed [sgbf_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic signed [sgbf_pkg::CV_W-1:0]       lowpass_cv_i,
  input  logic signed [sgbf_pkg::CV_W-1:0]       highpass_cv_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [sgbf_pkg::CH_W-1:0]              channel_out_o,
  output logic signed [sgbf_pkg::SAMPLE_BITS-1:0] sample_out_o
);
  import sgbf_pkg::*;

  logic [KNOB_W-1:0] lp_knob_q, hp_knob_q;
  logic              out_free;
  cmd_t              cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_knob_q <= LP_KNOB_RST;
      hp_knob_q <= HP_KNOB_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_HP) hp_knob_q <= pwdata[KNOB_W-1:0];
      else lp_knob_q <= pwdata[KNOB_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HP) ? 32'(hp_knob_q) : 32'(lp_knob_q);

  sgbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  sgbf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .lp_knob_i     (lp_knob_q),
    .hp_knob_i     (hp_knob_q),
    .channel_i     (channel_i),
    .sample_in_i   (sample_in_i),
    .lowpass_cv_i  (lowpass_cv_i),
    .highpass_cv_i (highpass_cv_i),
    .out_ready_i   (out_ready_i),
    .out_free_o    (out_free),
    .out_valid_o   (out_valid_o),
    .channel_out_o (channel_out_o),
    .sample_out_o  (sample_out_o)
  );

endmodule

[sv/sgbf_chk.sv]
// ----------------------------------------------------------------------------
// sgbf_chk
// Port-level checks of the band filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sgbf_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       pready,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic [sgbf_pkg::CH_W-1:0]  channel_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [sgbf_pkg::CH_W-1:0]  channel_out_o
);
  import sgbf_pkg::*;

  logic [CH_W-1:0] last_ch_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) last_ch_q <= channel_i;
  end

  `ASSERT_IMPL(a_pready_high, 1'b1, pready)
  `ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o)
  `ASSERT_NEXT(a_out_held, out_valid_o && !out_ready_i, out_valid_o && $stable(channel_out_o))
  `ASSERT_IMPL(a_out_channel, $rose(out_valid_o), channel_out_o == last_ch_q)

endmodule

bind smoothed_gearbox_iir_bandfilter_core sgbf_chk u_sgbf_chk (.*);

[sim/tb_smoothed_gearbox_iir_bandfilter_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_smoothed_gearbox_iir_bandfilter_core
// Self-checking bench for the band filter: directed and random samples on
// all channels, knob writes between phases, random idling on both sides,
// every result compared against a bit-true filter predictor.
// ----------------------------------------------------------------------------
module tb_smoothed_gearbox_iir_bandfilter_core;
  import sgbf_pkg::*;

  localparam int unsigned LP_ADDR = 0;
  localparam int unsigned HP_ADDR = 4;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [CH_W-1:0]               ch;
    logic signed [SAMPLE_BITS-1:0] smp;
  } filt_out_t;

  class band_scoreboard;
    longint lp_knob, hp_knob;
    int     hp_pole [CHANNELS][6];
    int     lp_pole [CHANNELS][6];
    longint lp_amt [CHANNELS];
    longint hp_amt [CHANNELS];
    longint lp_last [CHANNELS];
    longint hp_last [CHANNELS];
    int     gear [CHANNELS];
    filt_out_t pending [$];
    int errors;
    int checked;

    function new();
      lp_knob = 65536;
      hp_knob = 0;
      errors  = 0;
      checked = 0;
      for (int c = 0; c < CHANNELS; c++) begin
        for (int k = 0; k < 6; k++) begin
          hp_pole[c][k] = 0;
          lp_pole[c][k] = 0;
        end
        lp_amt[c]  = 65536;
        hp_amt[c]  = 0;
        lp_last[c] = 1000 * 65536;
        hp_last[c] = 1000 * 65536;
        gear[c]    = 0;
      end
    endfunction

    function longint floor_shr(longint v, int sh);
      if (v >= 0) return v >>> sh;
      return -((-v + (longint'(1) << sh) - 1) >>> sh);
    endfunction

    function longint clip(longint v, int bits);
      longint hi, lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function longint coef_target(longint knob, longint cv);
      longint t, p;
      t = knob * 5 + cv * 16;
      if (t < 655 * 5) t = 655 * 5;
      if (t > 64881 * 5) t = 64881 * 5;
      p = t / 5;
      return (p * p + (longint'(1) << 15)) >>> 16;
    endfunction

    function longint glide(longint amt, ref longint last, input longint tgt);
      longint d, diff, num, den, mag, q;
      d = last - tgt;
      if (d < 0) d = -d;
      diff = tgt - amt;
      last = tgt;
      num = d + 65536;
      den = d + 301 * 65536;
      mag = (diff < 0 ? -diff : diff) * num;
      q = (mag + den / 2) / den;
      return diff < 0 ? amt - q : amt + q;
    endfunction

    function int pole_next(int pole, longint x, longint amt);
      longint s;
      s = longint'(pole) * (65536 - amt) + x * amt;
      return int'(clip(floor_shr(s + 32768, 16), 32));
    endfunction

    function longint pole_pair(int ch, int k, longint x);
      hp_pole[ch][k] = pole_next(hp_pole[ch][k], x, hp_amt[ch]);
      x -= hp_pole[ch][k];
      lp_pole[ch][k] = pole_next(lp_pole[ch][k], x, lp_amt[ch]);
      return lp_pole[ch][k];
    endfunction

    function void write_knob(int addr, logic [31:0] val);
      if (addr == LP_ADDR) lp_knob = val & 32'h1FFFF;
      else if (addr == HP_ADDR) hp_knob = val & 32'h1FFFF;
    endfunction

    function void note_sample(logic [CH_W-1:0] ch, logic signed [SAMPLE_BITS-1:0] smp,
                              logic signed [CV_W-1:0] lcv, logic signed [CV_W-1:0] hcv);
      int c;
      longint x, y;
      filt_out_t r;
      c = ch;
      x = longint'(smp) * 256;
      lp_amt[c] = glide(lp_amt[c], lp_last[c], coef_target(lp_knob, longint'(lcv)));
      hp_amt[c] = glide(hp_amt[c], hp_last[c], coef_target(hp_knob, longint'(hcv)));
      gear[c] = gear[c] == 5 ? 0 : gear[c] + 1;
      x = pole_pair(c, 0, x);
      x = pole_pair(c, gear[c][0] ? 2 : 1, x);
      x = pole_pair(c, 3 + gear[c] % 3, x);
      y = clip(floor_shr(x + 128, 8), SAMPLE_BITS);
      r.ch = ch;
      r.smp = y[SAMPLE_BITS-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [CH_W-1:0] ch, logic signed [SAMPLE_BITS-1:0] smp);
      filt_out_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected transfer ch %0d sample %0d", $time, ch, smp);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.ch !== ch) begin
        $display("%0t: channel exp %0d got %0d", $time, e.ch, ch);
        errors++;
      end
      if (e.smp !== smp) begin
        $display("%0t: sample exp %0d got %0d", $time, e.smp, smp);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [CH_W-1:0] channel_i = '0;
  logic signed [SAMPLE_BITS-1:0] sample_in_i = '0;
  logic signed [CV_W-1:0] lowpass_cv_i = '0;
  logic signed [CV_W-1:0] highpass_cv_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [CH_W-1:0] channel_out_o;
  logic signed [SAMPLE_BITS-1:0] sample_out_o;

  band_scoreboard sb = new();
  bit calm = 1'b0;
  longint cycles = 0;
  int sent = 0;

  always #5 clk_i = ~clk_i;

  smoothed_gearbox_iir_bandfilter_core i_dut (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("smoothed_gearbox_iir_bandfilter_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(channel_out_o, sample_out_o);
    out_ready_i <= calm || ($urandom_range(99) >= 38);
  end

  task automatic write_reg(int addr, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= PADDR_W'(addr); pwdata <= val; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.write_knob(addr, val);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send(logic [CH_W-1:0] ch, logic signed [SAMPLE_BITS-1:0] smp,
                      logic signed [CV_W-1:0] lcv, logic signed [CV_W-1:0] hcv);
    if (!calm && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 38);
    end
    in_valid_i <= 1'b1;
    channel_i <= ch; sample_in_i <= smp; lowpass_cv_i <= lcv; highpass_cv_i <= hcv;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(ch, smp, lcv, hcv);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic signed [CV_W-1:0] rand_cv();
    case ($urandom_range(4))
      0: return 17'sd40960;
      1: return -17'sd40960;
      2: return CV_W'($urandom);
      default: return CV_W'($urandom_range(81920)) - 17'sd40960;
    endcase
  endfunction

  task automatic random_burst(int n);
    logic signed [SAMPLE_BITS-1:0] s;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: s = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
        1: s = SAMPLE_BITS'($urandom_range(8191)) - 24'sd4096;
        default: s = SAMPLE_BITS'($urandom);
      endcase
      send(CH_W'($urandom), s, rand_cv(), rand_cv());
    end
  endtask

  initial begin
    logic [31:0] knobs [6] = '{32'd65536, 32'd0, 32'd32768, 32'd1000, 32'hFFFFFFFF, 32'd50000};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(4'd0, 24'sh7FFFFF, 17'sd40960, -17'sd40960);
    send(4'd0, 24'sh7FFFFF, 17'sd40960, -17'sd40960);
    send(4'd1, 24'sh800000, -17'sd40960, 17'sd40960);
    send(4'd15, 24'sh000000, 17'sd0, 17'sd0);
    send(4'd15, 24'sh000001, 17'sd0, 17'sd40960);
    send(4'd2, -24'sd1, 17'h1FFFF, 17'h10000);
    for (int g = 0; g < 8; g++) send(4'd3, 24'sh400000, 17'sd0, 17'sd0);
    for (int g = 0; g < 6; g++) send(4'd4, (g % 2) ? 24'sh7FFFFF : 24'sh800000, -17'sd20000, 17'sd20000);
    drain();
    write_reg(HP_ADDR, 32'd65536);
    write_reg(LP_ADDR, 32'd0);
    random_burst(40);
    drain();
    for (int p = 0; p < 6; p++) begin
      write_reg(LP_ADDR, knobs[p]);
      write_reg(HP_ADDR, knobs[5 - p]);
      calm = (p == 2);
      random_burst(290);
      drain();
    end
    calm = 1'b0;
    $display("Covered %0d samples on all channels over several knob settings,", sent);
    $display("%0d results compared including saturation and gear rotation.", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("smoothed_gearbox_iir_bandfilter_core: match");
    else
      $display("smoothed_gearbox_iir_bandfilter_core: mismatch");
    $finish;
  end

endmodule
